@@ design/sbc_pkg.sv @@
// Package for the sensor bias calibration sequencer: widths, register and
// mode codes, request structs and the averaging and scaling arithmetic.
// No dependencies.
`default_nettype none

package sbc_pkg;

  localparam int unsigned CalibSamples = 200;

  localparam int unsigned RawW     = 16;
  localparam int unsigned AccW     = 24;
  localparam int unsigned CntW     = 8;
  localparam int unsigned SecW     = 16;
  localparam int unsigned OutW     = 32;
  localparam int unsigned ScaleW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CalModeW = 2;

  // averaging: x = |sum| * 256 + N/2, q = x / N by reciprocal and one fix-up
  localparam int unsigned AvgW   = AccW + 8;
  localparam int unsigned RecipW = 33;
  localparam logic [RecipW-1:0] AvgRecip = RecipW'((64'd1 << 32) / CalibSamples);
  localparam logic [AvgW-1:0]   AvgBias  = AvgW'(CalibSamples / 2);
  localparam logic [AvgW-1:0]   AvgDiv   = AvgW'(CalibSamples);
  localparam logic [CntW-1:0]   CalibCnt = CntW'(CalibSamples);

  // scaling: Q.8 difference times Q.24 scale
  localparam int unsigned DiffW = AccW + 2;
  localparam int unsigned ProdW = DiffW + ScaleW;
  localparam int unsigned QW    = ProdW - 16;

  localparam logic [ScaleW-1:0] ScaleRst  = 32'h0100_0000;
  localparam logic [SecW-1:0]   PeriodRst = 16'd60;

  localparam int unsigned TdataInW  = 6 * RawW;
  localparam int unsigned TdataOutW = 6 * OutW + 3 * AccW;
  localparam int unsigned TuserOutW = ModeW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAL_MODE    = 2'd0,
    REG_ACCEL_SCALE = 2'd1,
    REG_GYRO_SCALE  = 2'd2,
    REG_PERIOD      = 2'd3
  } cfg_reg_e;

  typedef enum logic [CalModeW-1:0] {
    CAL_NEVER    = 2'd0,
    CAL_ONCE     = 2'd1,
    CAL_PERIODIC = 2'd2,
    CAL_ONCE_ALT = 2'd3
  } cal_mode_e;

  localparam logic [ModeW-1:0] MODE_CODE_UNCAL = 2'd0;
  localparam logic [ModeW-1:0] MODE_CODE_CAL   = 2'd1;
  localparam logic [ModeW-1:0] MODE_CODE_READY = 2'd2;

  typedef enum logic [2:0] {
    ModeUncal = 3'b001,
    ModeCal   = 3'b010,
    ModeReady = 3'b100
  } mode_e;

  typedef struct packed {
    logic [CalModeW-1:0] cal_mode;
    logic [ScaleW-1:0]   accel_scale;
    logic [ScaleW-1:0]   gyro_scale;
    logic [SecW-1:0]     period;
  } cfg_t;

  typedef struct packed {
    logic                cmd;
    logic [2:0][RawW-1:0] gyro;
    logic [2:0][RawW-1:0] accel;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0]     mode_code;
    logic                 data_valid;
    logic [2:0][OutW-1:0] gyro_out;
    logic [2:0][OutW-1:0] accel_out;
    logic [2:0][AccW-1:0] gravity;
  } result_t;

  function automatic logic [ModeW-1:0] mode_code(input mode_e m);
    logic [ModeW-1:0] c;
    unique case (m)
      ModeUncal: c = MODE_CODE_UNCAL;
      ModeCal:   c = MODE_CODE_CAL;
      ModeReady: c = MODE_CODE_READY;
      default:   c = MODE_CODE_UNCAL;
    endcase
    return c;
  endfunction

  // Q.8 average of a sum, rounded half away from zero
  function automatic logic [AccW-1:0] avg_q8(input logic [AccW-1:0] sum);
    logic                     neg;
    logic [AccW-1:0]          mag;
    logic [AvgW-1:0]          x;
    logic [AvgW+RecipW-1:0]   prod;
    logic [AvgW-1:0]          q;
    logic [AvgW-1:0]          qn;
    logic [AvgW-1:0]          r;
    neg  = sum[AccW-1];
    mag  = neg ? (~sum + 1'b1) : sum;
    x    = {mag, 8'h00} + AvgBias;
    prod = (AvgW + RecipW)'(x) * (AvgW + RecipW)'(AvgRecip);
    q    = AvgW'(prod >> 32);
    qn   = AvgW'(q * AvgDiv);
    r    = x - qn;
    if (r >= AvgDiv) begin
      q = q + 1'b1;
    end
    return neg ? AccW'(~q + 1'b1) : AccW'(q);
  endfunction

  // Q.8 value times Q.24 scale to Q16.16, rounded, saturated
  function automatic logic [OutW-1:0] scale_q16(input logic [DiffW-1:0] v,
                                                input logic [ScaleW-1:0] scale);
    logic             neg;
    logic [DiffW-1:0] mag;
    logic [ProdW-1:0] prod;
    logic [QW-1:0]    q;
    logic [OutW-1:0]  res;
    neg  = v[DiffW-1];
    mag  = neg ? (~v + 1'b1) : v;
    prod = ProdW'(mag) * ProdW'(scale);
    q    = QW'((prod + ProdW'(32768)) >> 16);
    if (neg) begin
      res = (q > QW'(64'h8000_0000)) ? 32'h8000_0000 : OutW'(~q + 1'b1);
    end else begin
      res = (q > QW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : OutW'(q);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/sbc_cfg.sv @@
// Configuration registers of the calibration sequencer.
// Depends on sbc_pkg.
`default_nettype none

module sbc_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sbc_pkg::CfgDataW-1:0] cfg_data_i,
  output sbc_pkg::cfg_t                    cfg_o
);
  import sbc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CAL_MODE:    cfg_d.cal_mode    = cfg_data_i[CalModeW-1:0];
        REG_ACCEL_SCALE: cfg_d.accel_scale = cfg_data_i[ScaleW-1:0];
        REG_GYRO_SCALE:  cfg_d.gyro_scale  = cfg_data_i[ScaleW-1:0];
        REG_PERIOD:      cfg_d.period      = cfg_data_i[SecW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_mode    <= CAL_ONCE;
      cfg_q.accel_scale <= ScaleRst;
      cfg_q.gyro_scale  <= ScaleRst;
      cfg_q.period      <= PeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ design/sbc_engine.sv @@
// Calibration state (mode, sums, counters) and the single-pass datapath
// that forms one result per sample. Depends on sbc_pkg.
`default_nettype none

module sbc_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire sbc_pkg::item_t  item_i,
  input  wire sbc_pkg::cfg_t   cfg_i,
  output sbc_pkg::result_t     res_o
);
  import sbc_pkg::*;

  mode_e                mode_q, mode_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [SecW-1:0]      sec_q, sec_d;
  logic [2:0][AccW-1:0] gacc_q, gacc_d;
  logic [2:0][AccW-1:0] aacc_q, aacc_d;

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    sec_d  = sec_q;
    gacc_d = gacc_q;
    aacc_d = aacc_q;
    res_o  = '0;
    if (item_i.cmd) begin
      if (sec_q != '1) begin
        sec_d = sec_q + 1'b1;
      end
    end else begin
      unique case (mode_q)
        ModeUncal: begin
          if (cfg_i.cal_mode != CAL_NEVER) begin
            gacc_d = '0;
            aacc_d = '0;
            cnt_d  = '0;
            sec_d  = '0;
            mode_d = ModeCal;
          end else begin
            mode_d = ModeReady;
          end
        end
        ModeCal: begin
          if (cnt_q < CalibCnt) begin
            for (int i = 0; i < 3; i++) begin
              gacc_d[i] = gacc_q[i] + AccW'($signed(item_i.gyro[i]));
              aacc_d[i] = aacc_q[i] + AccW'($signed(item_i.accel[i]));
            end
            cnt_d = cnt_q + 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              gacc_d[i] = avg_q8(gacc_q[i]);
              aacc_d[i] = avg_q8(aacc_q[i]);
            end
            cnt_d  = '0;
            mode_d = ModeReady;
          end
        end
        ModeReady: begin
          res_o.data_valid = 1'b1;
          for (int i = 0; i < 3; i++) begin
            res_o.gyro_out[i] = scale_q16(
                DiffW'($signed({item_i.gyro[i], 8'h00})) - DiffW'($signed(gacc_q[i])),
                cfg_i.gyro_scale);
            res_o.accel_out[i] = scale_q16(
                DiffW'($signed({item_i.accel[i], 8'h00})), cfg_i.accel_scale);
          end
          // periodic check comes after the output is formed
          if (cfg_i.cal_mode == CAL_PERIODIC && sec_q > cfg_i.period) begin
            mode_d = ModeUncal;
          end
        end
        default: mode_d = ModeUncal;
      endcase
      res_o.mode_code = mode_code(mode_d);
      if (mode_d == ModeReady) begin
        res_o.gravity = aacc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeUncal;
      cnt_q  <= '0;
      sec_q  <= '0;
      gacc_q <= '0;
      aacc_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      sec_q  <= sec_d;
      gacc_q <= gacc_d;
      aacc_q <= aacc_d;
    end
  end

endmodule

`default_nettype wire

@@ design/sensor_bias_calibration_sequencer_unit.sv @@
// Sensor bias calibration sequencer, top level: input register, engine,
// result register. Throughput one request per cycle; the result register
// stalls only on m_axis_tready. Tick requests advance the seconds counter
// and give no result. Reset clears mode, sums, counters and handshakes;
// registers return to calibrate-once, unity scales and a 60 s period.
`default_nettype none

module sensor_bias_calibration_sequencer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z raw
  input  wire logic [sbc_pkg::TdataInW-1:0]  s_axis_tdata,
  // cmd
  input  wire logic [0:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // gyro_x/y/z_out, accel_x/y/z_out, gravity_x/y/z
  output logic [sbc_pkg::TdataOutW-1:0]      m_axis_tdata,
  // mode_after, data_valid
  output logic [sbc_pkg::TuserOutW-1:0]      m_axis_tuser,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sbc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sbc_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q, in_valid_d;
  result_t res, out_res_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;

  sbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sbc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance       = in_valid_q && (in_item_q.cmd || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance && !in_item_q.cmd) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd   <= s_axis_tuser[0];
      in_item_q.gyro  <= s_axis_tdata[3*RawW-1:0];
      in_item_q.accel <= s_axis_tdata[6*RawW-1:3*RawW];
    end
    if (advance && !in_item_q.cmd) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.gravity, out_res_q.accel_out, out_res_q.gyro_out};
  assign m_axis_tuser  = {out_res_q.data_valid, out_res_q.mode_code};

endmodule

`default_nettype wire

@@ design/sbc_checker.sv @@
// Port-level checks for the calibration sequencer, bound to the top level.
// Depends on sbc_pkg and sensor_bias_calibration_sequencer_unit.
`default_nettype none

module sbc_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [sbc_pkg::TdataOutW-1:0] m_axis_tdata,
  input  wire logic [sbc_pkg::TuserOutW-1:0] m_axis_tuser
);
  import sbc_pkg::*;

  localparam int unsigned ScaledW = 6 * OutW;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[ModeW] |-> m_axis_tdata[ScaledW-1:0] == '0)
    else $error("scaled outputs not zero outside ready");

  a_gravity_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[ModeW-1:0] != MODE_CODE_READY |->
      m_axis_tdata[TdataOutW-1:ScaledW] == '0)
    else $error("gravity shown outside ready");

  a_valid_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[ModeW] |->
      m_axis_tuser[ModeW-1:0] == MODE_CODE_READY ||
      m_axis_tuser[ModeW-1:0] == MODE_CODE_UNCAL)
    else $error("scaled result with calibrating mode");

endmodule

bind sensor_bias_calibration_sequencer_unit sbc_checker u_sbc_checker (.*);

`default_nettype wire
